// ----- hw/rtl/srti_pkg.sv -----
// Package for the sorted region table insert block.
// Table geometry, field widths and result status codes; no dependencies.
`default_nettype none

package srti_pkg;

    // Table geometry
    localparam int ENTRIES   = 64;
    localparam int ADDR_BITS = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int END_W     = ADDR_BITS + 1;
    localparam int ROW_W     = 2 * ADDR_BITS;

    // Port field widths
    localparam int IN_W     = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    typedef logic [ROW_W-1:0] row_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_region_table_insert.sv -----
// Top level of the sorted region table insert block: sequencer, table memory
// and result register. Depends on srti_pkg.
`default_nettype none

// Channel   Ports                                   Direction  Transfer
// input     s_valid s_ready s_region_base           in         s_valid & s_ready
//           s_region_length
// result    m_valid m_ready m_status                out        m_valid & m_ready
//           m_slot_position m_entry_count
//
// One item at a time: s_ready is high only while the sequencer is idle.
// A full table goes straight to the result; an empty one writes row 0 and
// then answers. Otherwise one read port of the table memory sets the pace:
// the scan reads one row per cycle and stops at the insert point, or runs on
// to a tail check behind the last row; the shift then moves the rows from the
// insert point up by one, from the top row down; then comes one write and the
// result.
// Reset clears the sequencer, the entry count and the result valid; the
// table rows need no clearing since only written rows are ever read.
// A stalled result holds in the output register; the sequencer waits for it
// to drain before loading the next one, and s_ready returns on that same edge.

module sorted_region_table_insert
    import srti_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [IN_W-1:0]     s_region_base,
    input  wire logic [IN_W-1:0]     s_region_length,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [SLOT_W-1:0]        m_slot_position,
    output logic [COUNT_W-1:0]       m_entry_count
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Table memory: base in the upper half of a row, length in the lower
    row_t mem [ENTRIES];

    logic [2:0]            state_reg, state_next;
    logic [ADDR_BITS-1:0]  base_reg, base_next;
    logic [ADDR_BITS-1:0]  len_reg, len_next;
    logic [END_W-1:0]      new_end_reg, new_end_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  issue_reg, issue_next;
    logic                  rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    row_t                  rd_data_reg;
    logic [END_W-1:0]      prev_end_reg, prev_end_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    row_t                  mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;

    logic [ADDR_BITS-1:0]  rd_base, rd_len;
    logic [END_W-1:0]      rd_base_ext, rd_end, base_ext;
    logic [IN_W+ADDR_BITS-1:0] in_base_wide, in_len_wide;
    logic [ADDR_BITS-1:0]  in_base, in_len;
    logic [CNT_W-1:0]      count_m1;
    logic [IDX_W+SLOT_W-1:0]   slot_wide;
    logic [CNT_W+COUNT_W-1:0]  count_wide;
    logic                  in_xfer, out_free;
    logic                  scan_stop, scan_fit;

    assign s_ready = (state_reg == S_IDLE);
    assign in_xfer = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;

    // Take the low ADDR_BITS of each input field
    assign in_base_wide = {{ADDR_BITS{1'b0}}, s_region_base};
    assign in_len_wide  = {{ADDR_BITS{1'b0}}, s_region_length};
    assign in_base      = in_base_wide[ADDR_BITS-1:0];
    assign in_len       = in_len_wide[ADDR_BITS-1:0];

    assign rd_base     = rd_data_reg[ROW_W-1:ADDR_BITS];
    assign rd_len      = rd_data_reg[ADDR_BITS-1:0];
    assign rd_base_ext = {1'b0, rd_base};
    assign rd_end      = rd_base_ext + {1'b0, rd_len};
    assign base_ext    = {1'b0, base_reg};
    assign count_m1    = count_reg - CNT_W'(1);

    assign slot_wide  = {{SLOT_W{1'b0}}, pos_reg};
    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    // Fit test on the row just read: in front of the head, or between
    // the previous row and this one
    always_comb begin
        scan_stop = 1'b0;
        scan_fit  = 1'b0;
        if (rd_idx_reg == '0) begin
            if (base_ext < rd_base_ext) begin
                scan_stop = 1'b1;
                scan_fit  = (new_end_reg <= rd_base_ext);
            end
        end else if ((prev_end_reg <= base_ext) && (rd_base_ext >= new_end_reg)) begin
            scan_stop = 1'b1;
            scan_fit  = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        new_end_next    = new_end_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        issue_next      = issue_reg;
        rvalid_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        prev_end_next   = prev_end_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_count_next    = m_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = {base_reg, len_reg};
        mem_raddr       = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    base_next    = in_base;
                    len_next     = in_len;
                    new_end_next = {1'b0, in_base} + {1'b0, in_len};
                    last_next    = count_m1[IDX_W-1:0];
                    pos_next     = '0;
                    idx_next     = '0;
                    issue_next   = 1'b1;
                    if (count_reg >= CNT_W'(ENTRIES)) begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = S_WRITE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue reads in ascending order, one row per cycle
                if (issue_reg) begin
                    rvalid_next = 1'b1;
                    rd_idx_next = idx_reg;
                    if (idx_reg == last_reg) begin
                        issue_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                if (rvalid_reg) begin
                    prev_end_next = rd_end;
                    if (scan_stop) begin
                        if (scan_fit) begin
                            // Start the shift from the top row down
                            pos_next    = rd_idx_reg;
                            idx_next    = last_reg;
                            issue_next  = 1'b1;
                            rvalid_next = 1'b0;
                            state_next  = S_SHIFT;
                        end else begin
                            res_status_next = ST_OVERLAP;
                            state_next      = S_DONE;
                        end
                    end else if (rd_idx_reg == last_reg) begin
                        state_next = S_TAIL;
                    end
                end
            end

            S_TAIL: begin
                // prev_end now holds the tail's end
                if (prev_end_reg <= base_ext) begin
                    pos_next   = count_reg[IDX_W-1:0];
                    state_next = S_WRITE;
                end else begin
                    res_status_next = ST_OVERLAP;
                    state_next      = S_DONE;
                end
            end

            S_SHIFT: begin
                // Read row j, write it to row j+1 in the cycle after
                if (issue_reg) begin
                    rvalid_next = 1'b1;
                    rd_idx_next = idx_reg;
                    if (idx_reg == pos_reg) begin
                        issue_next = 1'b0;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                if (rvalid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg + IDX_W'(1);
                    mem_wdata = rd_data_reg;
                    if (rd_idx_reg == pos_reg) begin
                        state_next = S_WRITE;
                    end
                end
            end

            S_WRITE: begin
                mem_we          = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_INSERTED;
                state_next      = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = slot_wide[SLOT_W-1:0];
                    m_count_next  = count_wide[COUNT_W-1:0];
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            issue_reg   <= 1'b0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            rvalid_reg  <= rvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        base_reg       <= base_next;
        len_reg        <= len_next;
        new_end_reg    <= new_end_next;
        last_reg       <= last_next;
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        prev_end_reg   <= prev_end_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_slot_position = m_slot_reg;
    assign m_entry_count   = m_count_reg;

endmodule

`default_nettype wire

// ----- test/tb_sorted_region_table_insert.sv -----
// Self-checking testbench for sorted_region_table_insert: region insert requests go in,
// and each result is checked against a local model of the sorted table.
// Depends on srti_pkg and the block's top level. Nothing else is needed.

module tb_sorted_region_table_insert;

    import srti_pkg::*;

    localparam longint unsigned ADDR_MAX = (64'd1 << ADDR_BITS) - 1;
    localparam longint unsigned MAX_END  = 2 * ADDR_MAX;
    localparam int unsigned WATCHDOG_CYCLES = 4000;
    localparam int unsigned HOLD_CYCLES     = 500;
    localparam int unsigned DRAIN_CYCLES    = 2 * ENTRIES + 8;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Request channel
    logic            s_valid         = 1'b0;
    logic            s_ready;
    logic [IN_W-1:0] s_region_base   = '0;
    logic [IN_W-1:0] s_region_length = '0;

    // Result channel
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_slot_position;
    logic [COUNT_W-1:0]  m_entry_count;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } insert_result_t;

    // Model of the table contents, kept in ascending order of base
    logic [ADDR_BITS-1:0] held_base [ENTRIES];
    logic [ADDR_BITS-1:0] held_len  [ENTRIES];
    int unsigned          held_count = 0;

    // Results owed by the block, oldest first
    insert_result_t pending_results [$];

    // Bookkeeping
    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned placed_seen    = 0;
    int unsigned overlap_seen   = 0;
    int unsigned full_seen      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned tx_burst       = 0;
    int unsigned rx_burst       = 0;
    bit          hold_results   = 1'b0;

    sorted_region_table_insert i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_region_base   (s_region_base),
        .s_region_length (s_region_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot_position (m_slot_position),
        .m_entry_count   (m_entry_count)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // End of a held region, one bit wider than an address so it never wraps.
    function automatic logic [END_W-1:0] region_end(input int unsigned idx);
        return {1'b0, held_base[idx]} + held_len[idx];
    endfunction

    // Try to place one region: return the result the block owes and update the model.
    function automatic insert_result_t place_region(input logic [IN_W-1:0] base_in,
                                                     input logic [IN_W-1:0] len_in);
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] len;
        logic [END_W-1:0]     new_end;
        int unsigned          pos;
        int unsigned          i;
        bit                   fits;
        insert_result_t       res;
        base    = ADDR_BITS'(base_in);
        len     = ADDR_BITS'(len_in);
        new_end = {1'b0, base} + len;
        pos     = 0;
        fits    = 1'b0;
        res     = '0;

        // Full table: refuse, leave everything as is
        if (held_count >= ENTRIES) begin
            res.status = ST_FULL;
            res.count  = COUNT_W'(held_count);
            return res;
        end

        if (held_count == 0) begin
            // Empty table takes anything at the head
            fits = 1'b1;
        end else if (base < held_base[0]) begin
            // Below the head: only in front, and only if it ends in time
            fits = (new_end <= {1'b0, held_base[0]});
        end else begin
            // First pair of neighbors that leaves room wins
            for (i = 0; i + 1 < held_count; i++) begin
                if (!fits && region_end(i) <= base && held_base[i + 1] >= new_end) begin
                    fits = 1'b1;
                    pos  = i + 1;
                end
            end
            // Otherwise append behind the tail if it ends in time
            if (!fits && region_end(held_count - 1) <= base) begin
                fits = 1'b1;
                pos  = held_count;
            end
        end

        if (!fits) begin
            res.status = ST_OVERLAP;
            res.count  = COUNT_W'(held_count);
            return res;
        end

        // Shift the upper part up by one and drop the new region in
        for (i = held_count; i > pos; i--) begin
            held_base[i] = held_base[i - 1];
            held_len[i]  = held_len[i - 1];
        end
        held_base[pos] = base;
        held_len[pos]  = len;
        held_count++;
        res.status = ST_INSERTED;
        res.slot   = SLOT_W'(pos);
        res.count  = COUNT_W'(held_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Idle span: mostly none or short, a few long, now and then a run with none.
    function automatic int unsigned idle_span(inout int unsigned burst_left);
        int unsigned pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            burst_left = $urandom_range(16, 48);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Uniform-ish value in 0..bound for bounds wider than 32 bits.
    function automatic longint unsigned rand_upto(input longint unsigned bound);
        longint unsigned r;
        r = {$urandom(), $urandom()};
        return r % (bound + 1);
    endfunction

    // Region that fits a free span of the current table, with random content.
    function automatic void fitting_region(output logic [IN_W-1:0] base_o,
                                           output logic [IN_W-1:0] len_o);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned top;
        longint unsigned b;
        longint unsigned room;
        longint unsigned cap;
        int unsigned     slot;
        int unsigned     tries;
        int unsigned     mode;
        slot = 0;
        lo   = 0;
        hi   = 0;
        // Prefer a span with room in it; zero-size spans still get picked at times
        for (tries = 0; tries < 4; tries++) begin
            slot = $urandom_range(0, held_count);
            lo   = (slot == 0) ? 0 : region_end(slot - 1);
            hi   = (slot == held_count) ? MAX_END : held_base[slot];
            if (hi > lo && lo <= ADDR_MAX) break;
        end
        if (lo > ADDR_MAX) begin
            base_o = $urandom();
            len_o  = $urandom();
            return;
        end
        top  = (hi < ADDR_MAX) ? hi : ADDR_MAX;
        mode = $urandom_range(0, 9);
        b    = (mode < 3) ? lo : lo + rand_upto((top - lo) / 2);
        room = hi - b;
        cap  = (room < ADDR_MAX) ? room : ADDR_MAX;
        // Exact fill or abut the upper neighbor; small regions otherwise to keep space
        if ((mode == 2 || mode == 9) && slot != held_count)
            len_o = IN_W'(cap);
        else
            len_o = IN_W'(rand_upto(cap / 16));
        base_o = IN_W'(b);
    endfunction

    // Region that grazes or repeats a held one: overlaps by one byte on either side,
    // or is an exact copy.
    function automatic void near_miss_region(output logic [IN_W-1:0] base_o,
                                             output logic [IN_W-1:0] len_o);
        longint unsigned start;
        longint unsigned stop;
        longint unsigned span;
        int unsigned     j;
        int unsigned     mode;
        if (held_count == 0) begin
            base_o = $urandom();
            len_o  = $urandom();
            return;
        end
        j     = $urandom_range(0, held_count - 1);
        start = held_base[j];
        stop  = region_end(j);
        mode  = $urandom_range(0, 2);
        span  = $urandom_range(1, 4096);
        if (mode == 0 && start + 1 >= span) begin
            // End one byte past the held base
            base_o = IN_W'(start + 1 - span);
            len_o  = IN_W'(span);
        end else if (mode == 1 && stop >= 1) begin
            // Start one byte before the held end
            base_o = IN_W'(stop - 1);
            len_o  = IN_W'(span);
        end else begin
            base_o = held_base[j];
            len_o  = held_len[j];
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one region after a random idle span and hold it until the transfer.
    task automatic send_region(input logic [IN_W-1:0] base, input logic [IN_W-1:0] len);
        int unsigned gap;
        gap = idle_span(tx_burst);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_region_base   <= base;
        s_region_length <= len;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(place_region(base, len));
        requests_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive m_ready with random stalls; on request hold off for a long stretch.
    initial begin : result_ready_driver
        int unsigned span;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
            end else begin
                span = idle_span(rx_burst);
                m_ready <= (span == 0);
                if (span > 1) repeat (span - 1) @(negedge aclk);
            end
        end
    end

    task automatic report_mismatch(input string what, input insert_result_t want,
                                   input insert_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected status=%0d slot=%0d count=%0d, got status=%0d slot=%0d count=%0d",
                     $time, what, want.status, want.slot, want.count,
                     got.status, got.slot, got.count);
    endtask

    // Compare every result transfer with the oldest owed result.
    always @(posedge aclk) begin : result_check
        insert_result_t want;
        insert_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status = m_status;
            got.slot   = m_slot_position;
            got.count  = m_entry_count;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.count !== want.count)
                    report_mismatch("result mismatch", want, got);
                case (want.status)
                    ST_INSERTED: placed_seen++;
                    ST_OVERLAP:  overlap_seen++;
                    default:     full_seen++;
                endcase
            end
        end
    end

    // Abort when no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: no transfer for %0d cycles, %0d results owed",
                         WATCHDOG_CYCLES, pending_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table accepts the first region at the head.
    task automatic test_empty_table();
        send_region(32'h8000_0000, 32'h0000_1000);
    endtask

    // Place in front and behind the tail, abutting exactly and overlapping by one.
    task automatic test_front_and_tail();
        send_region(32'h7FFF_F000, 32'h0000_1000);
        send_region(32'h7FFF_E000, 32'h0000_1001);
        send_region(32'h8000_1000, 32'h0000_0000);
        send_region(32'h8000_1000, 32'h0000_0010);
        send_region(32'h8000_100F, 32'h0000_0010);
    endtask

    // Fill a gap between neighbors exactly, miss it by one, hit inside an entry,
    // and drop a zero-length region where two entries abut.
    task automatic test_gap_fill();
        send_region(32'h9000_0000, 32'h0000_1000);
        send_region(32'h8000_0800, 32'h0000_0100);
        send_region(32'h8000_1010, 32'h0FFF_EFF1);
        send_region(32'h8000_1010, 32'h0FFF_EFF0);
        send_region(32'h8000_1010, 32'h0000_0000);
    endtask

    // Extreme bases and lengths, with ends that need the extra bit.
    task automatic test_wide_ends();
        send_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_region(32'hF000_0000, 32'h1000_0000);
        send_region(32'hF000_0000, 32'h0FFF_FFFF);
        send_region(32'h0000_0000, 32'hFFFF_FFFF);
        send_region(32'h0000_0000, 32'h7FFF_F000);
        send_region(32'hFFFF_FFFF, 32'h0000_0000);
        send_region(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // Mostly regions that fit or graze held ones, plus fully random ones.
    task automatic test_random_mix(input int unsigned items);
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] l;
        int unsigned     k;
        int unsigned     pick;
        for (k = 0; k < items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                fitting_region(b, l);
            end else if (pick < 45) begin
                b = $urandom();
                l = $urandom();
            end else begin
                near_miss_region(b, l);
            end
            send_region(b, l);
        end
    endtask

    // Hold off results for a long stretch while requests keep coming, so the
    // block backs up and stalls its input.
    task automatic test_result_backpressure();
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] l;
        int unsigned     k;
        hold_results = 1'b1;
        for (k = 0; k < 6; k++) begin
            if (k[0])
                near_miss_region(b, l);
            else
                fitting_region(b, l);
            send_region(b, l);
        end
    endtask

    // Top the table up to capacity, then check that everything is refused.
    task automatic test_table_full();
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] l;
        int unsigned     guard;
        for (guard = 0; guard < 400 && held_count < ENTRIES; guard++) begin
            fitting_region(b, l);
            send_region(b, l);
        end
        send_region('0, '0);
        send_region('1, '1);
        send_region(held_base[0], held_len[0]);
        fitting_region(b, l);
        send_region(b, l);
        near_miss_region(b, l);
        send_region(b, l);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_front_and_tail();
        test_gap_fill();
        test_wide_ends();
        test_random_mix(150);
        test_result_backpressure();
        test_random_mix(190);
        test_table_full();

        // Drop valid, drain owed results, then give the block time to settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d insert requests: %0d placed, %0d overlapping, %0d refused as full",
                 requests_sent, placed_seen, overlap_seen, full_seen);
        $display("table ended with %0d of %0d regions; %0d result mismatches",
                 held_count, ENTRIES, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/srti_pkg.sv
hw/rtl/sorted_region_table_insert.sv
test/tb_sorted_region_table_insert.sv
